FILE: rtl/core/pqms_pkg.sv
package pqms_pkg;

    localparam int DEPTH         = 16;
    localparam int VALUE_BITS    = 16;
    localparam int PRIORITY_BITS = 4;
    localparam int IDX_BITS      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS      = $clog2(DEPTH + 1);

    typedef logic [1:0]               cmd_t;
    typedef logic [1:0]               status_t;
    typedef logic [VALUE_BITS-1:0]    value_t;
    typedef logic [PRIORITY_BITS-1:0] prio_t;
    typedef logic [IDX_BITS-1:0]      idx_t;
    typedef logic [CNT_BITS-1:0]      cnt_t;

    localparam cmd_t CMD_ENQUEUE = 2'd0;
    localparam cmd_t CMD_DEQUEUE = 2'd1;
    localparam cmd_t CMD_PEEK    = 2'd2;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_OVERFLOW  = 2'd1;
    localparam status_t STATUS_UNDERFLOW = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        value_t value;
        prio_t  prio;
    } entry_t;

    // running best as it travels down the row of cells
    typedef struct packed {
        logic   found;
        idx_t   idx;
        entry_t ent;
    } cand_t;

    typedef struct packed {
        logic   wr_en;
        logic   shift_en;
        cnt_t   count;
        idx_t   best_idx;
        entry_t item;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/pqms_if.sv
interface pqms_req_if;
    logic                 valid;
    logic                 ready;
    pqms_pkg::cmd_t       cmd;
    pqms_pkg::value_t     item_value;
    pqms_pkg::prio_t      item_priority;

    modport source (output valid, output cmd, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input cmd, input item_value, input item_priority,
                    output ready);
endinterface

interface pqms_rsp_if;
    logic                 valid;
    logic                 ready;
    pqms_pkg::value_t     out_value;
    pqms_pkg::prio_t      out_priority;
    pqms_pkg::status_t    status;
    pqms_pkg::cnt_t       occupancy;

    modport source (output valid, output out_value, output out_priority, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input out_value, input out_priority, input status,
                    input occupancy, output ready);
endinterface

FILE: rtl/core/pqms_cell.sv
module pqms_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pqms_pkg::idx_t       cell_idx,
    input  pqms_pkg::cell_ctrl_t ctrl,
    input  pqms_pkg::entry_t     next_entry,
    output pqms_pkg::entry_t     entry,
    input  pqms_pkg::cand_t      cand_in,
    output pqms_pkg::cand_t      cand_out
);

    pqms_pkg::entry_t entry_reg;
    pqms_pkg::entry_t entry_next;
    pqms_pkg::cand_t  cand_reg;
    pqms_pkg::cand_t  cand_next;
    pqms_pkg::cnt_t   my_pos;
    logic             in_queue;
    logic             take_own;
    logic             do_shift;
    logic             do_write;

    assign my_pos   = pqms_pkg::CNT_BITS'(cell_idx);
    assign in_queue = my_pos < ctrl.count;

    // strict compare keeps the earliest entry among equal priorities
    assign take_own = in_queue && (!cand_in.found || entry_reg.prio > cand_in.ent.prio);

    assign do_shift = ctrl.shift_en && (cell_idx >= ctrl.best_idx)
                      && ((my_pos + pqms_pkg::CNT_BITS'(1)) < ctrl.count);
    assign do_write = ctrl.wr_en && (my_pos == ctrl.count);

    always_comb
    begin
        entry_next = entry_reg;
        if (do_write)
        begin
            entry_next = ctrl.item;
        end
        else if (do_shift)
        begin
            entry_next = next_entry;
        end
    end

    always_comb
    begin
        cand_next = cand_in;
        if (take_own)
        begin
            cand_next.found = 1'b1;
            cand_next.idx   = cell_idx;
            cand_next.ent   = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

    assign entry    = entry_reg;
    assign cand_out = cand_reg;

endmodule

FILE: rtl/core/priority_queue_max_select.sv
// Bounded priority queue of DEPTH entries held in arrival order in a row of cells.
// Every command gives exactly one response beat. Enqueue, no-op codes and commands
// that overflow or underflow respond without a scan; a new command is taken only when idle
// and the response register is free or being drained. Peek and dequeue on a non-empty
// queue scan the row: the best candidate walks the cell row one cell per cycle,
// earliest entry winning among equal priorities, and on dequeue all cells behind the
// winner move up one place in the same cycle the response is loaded.
module priority_queue_max_select (
    input  logic        clk,
    input  logic        rst_n,
    pqms_req_if.sink    req,
    pqms_rsp_if.source  rsp
);

    pqms_pkg::state_t     state_reg;
    pqms_pkg::state_t     state_next;
    pqms_pkg::cnt_t       count_reg;
    pqms_pkg::cnt_t       count_next;
    pqms_pkg::idx_t       scan_cnt_reg;
    pqms_pkg::idx_t       scan_cnt_next;
    logic                 deq_reg;
    logic                 deq_next;

    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    pqms_pkg::value_t     out_value_reg;
    pqms_pkg::value_t     out_value_next;
    pqms_pkg::prio_t      out_priority_reg;
    pqms_pkg::prio_t      out_priority_next;
    pqms_pkg::status_t    status_reg;
    pqms_pkg::status_t    status_next;
    pqms_pkg::cnt_t       occupancy_reg;
    pqms_pkg::cnt_t       occupancy_next;

    logic                 accept;
    logic                 rsp_take;
    logic                 load_rsp;
    logic                 scan_done;
    logic                 is_full;
    logic                 is_empty;
    pqms_pkg::cell_ctrl_t ctrl;
    pqms_pkg::cand_t      best;

    pqms_pkg::entry_t     entries [pqms_pkg::DEPTH];
    pqms_pkg::cand_t      cands   [pqms_pkg::DEPTH + 1];

    assign req.ready = (state_reg == pqms_pkg::ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign rsp_take  = rsp_valid_reg && rsp.ready;
    assign is_full   = count_reg == pqms_pkg::CNT_BITS'(pqms_pkg::DEPTH);
    assign is_empty  = count_reg == '0;
    assign scan_done = (state_reg == pqms_pkg::ST_SCAN)
                       && (scan_cnt_reg == pqms_pkg::IDX_BITS'(pqms_pkg::DEPTH - 1));
    assign best      = cands[pqms_pkg::DEPTH];

    assign cands[0] = '0;

    for (genvar i = 0; i < pqms_pkg::DEPTH; i++)
    begin : g_cell
        pqms_pkg::entry_t nbr;

        if (i == pqms_pkg::DEPTH - 1)
        begin : g_last
            assign nbr = entries[i];
        end
        else
        begin : g_mid
            assign nbr = entries[i + 1];
        end

        pqms_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (pqms_pkg::IDX_BITS'(i)),
            .ctrl       (ctrl),
            .next_entry (nbr),
            .entry      (entries[i]),
            .cand_in    (cands[i]),
            .cand_out   (cands[i + 1])
        );
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        deq_next      = deq_reg;
        unique case (state_reg)
            pqms_pkg::ST_IDLE:
            begin
                scan_cnt_next = '0;
                if (accept && !is_empty
                    && (req.cmd == pqms_pkg::CMD_DEQUEUE || req.cmd == pqms_pkg::CMD_PEEK))
                begin
                    state_next = pqms_pkg::ST_SCAN;
                    deq_next   = req.cmd == pqms_pkg::CMD_DEQUEUE;
                end
            end
            pqms_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + pqms_pkg::IDX_BITS'(1);
                if (scan_done)
                begin
                    state_next = pqms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pqms_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs, cell control and response
    always_comb
    begin
        ctrl              = '0;
        ctrl.count        = count_reg;
        ctrl.best_idx     = best.idx;
        ctrl.item.value   = req.item_value;
        ctrl.item.prio    = req.item_priority;
        count_next        = count_reg;
        load_rsp          = 1'b0;
        out_value_next    = '0;
        out_priority_next = '0;
        status_next       = pqms_pkg::STATUS_OK;
        unique case (state_reg)
            pqms_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority case (1'b1)
                        req.cmd == pqms_pkg::CMD_ENQUEUE:
                        begin
                            load_rsp = 1'b1;
                            if (is_full)
                            begin
                                status_next = pqms_pkg::STATUS_OVERFLOW;
                            end
                            else
                            begin
                                ctrl.wr_en = 1'b1;
                                count_next = count_reg + pqms_pkg::CNT_BITS'(1);
                            end
                        end
                        req.cmd == pqms_pkg::CMD_DEQUEUE || req.cmd == pqms_pkg::CMD_PEEK:
                        begin
                            if (is_empty)
                            begin
                                load_rsp    = 1'b1;
                                status_next = pqms_pkg::STATUS_UNDERFLOW;
                            end
                        end
                        default:
                        begin
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end
            pqms_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    load_rsp          = 1'b1;
                    out_value_next    = best.ent.value;
                    out_priority_next = best.ent.prio;
                    if (deq_reg)
                    begin
                        ctrl.shift_en = 1'b1;
                        count_next    = count_reg - pqms_pkg::CNT_BITS'(1);
                    end
                end
            end
            default:
            begin
                load_rsp = 1'b0;
            end
        endcase
        occupancy_next = count_next;
        rsp_valid_next = load_rsp ? 1'b1 : (rsp_take ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pqms_pkg::ST_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            deq_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            deq_reg       <= deq_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            out_value_reg    <= out_value_next;
            out_priority_reg <= out_priority_next;
            status_reg       <= status_next;
            occupancy_reg    <= occupancy_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.out_value    = out_value_reg;
    assign rsp.out_priority = out_priority_reg;
    assign rsp.status       = status_reg;
    assign rsp.occupancy    = occupancy_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pqms_pkg::CNT_BITS'(pqms_pkg::DEPTH))
        else $error("entry count above depth");

    a_occ_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> occupancy_reg == count_reg)
        else $error("reported occupancy differs from held count");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == pqms_pkg::STATUS_OVERFLOW)
        |-> occupancy_reg == pqms_pkg::CNT_BITS'(pqms_pkg::DEPTH))
        else $error("overflow reported on a queue that is not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == pqms_pkg::STATUS_UNDERFLOW)
        |-> (occupancy_reg == '0 && out_value_reg == '0 && out_priority_reg == '0))
        else $error("underflow beat with data or entries");

    a_scan_rsp_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pqms_pkg::ST_SCAN) |-> !rsp_valid_reg)
        else $error("response register busy during a scan");

endmodule

FILE: bench/tb_priority_queue_max_select.sv
module tb_priority_queue_max_select;
    timeunit 1ns;
    timeprecision 1ps;

    import pqms_pkg::*;

    localparam cmd_t CMD_NOP      = 2'd3;
    localparam int RANDOM_ITEMS   = 1125;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 2 * (DEPTH + 1);

    typedef struct packed {
        value_t  value;
        prio_t   prio;
        status_t status;
        cnt_t    occupancy;
    } reply_t;

    // mirror of the queue contents; predicts one reply per accepted command
    class queue_mirror;
        value_t slot_value[DEPTH];
        prio_t  slot_prio[DEPTH];
        int     held;
        reply_t replies_due[$];
        int     failures;

        function new();
            held = 0;
            failures = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void apply_cmd(cmd_t c, value_t v, prio_t p);
            reply_t r;
            int     best;
            r = '0;
            case (c)
                CMD_ENQUEUE:
                    if (held == DEPTH)
                        r.status = STATUS_OVERFLOW;
                    else
                    begin
                        slot_value[held] = v;
                        slot_prio[held]  = p;
                        held++;
                    end
                CMD_DEQUEUE, CMD_PEEK:
                    if (held == 0)
                        r.status = STATUS_UNDERFLOW;
                    else
                    begin
                        // first strictly larger wins, so the earliest of a tie stays
                        best = 0;
                        for (int i = 1; i < held; i++)
                            if (slot_prio[i] > slot_prio[best])
                                best = i;
                        r.value = slot_value[best];
                        r.prio  = slot_prio[best];
                        if (c == CMD_DEQUEUE)
                        begin
                            for (int i = best; i + 1 < held; i++)
                            begin
                                slot_value[i] = slot_value[i + 1];
                                slot_prio[i]  = slot_prio[i + 1];
                            end
                            held--;
                        end
                    end
                default: ;
            endcase
            r.occupancy = cnt_t'(held);
            replies_due.push_back(r);
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name,
                         want, got);
                failures++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t ns: unexpected reply beat, expected none, actual %0h",
                         $time, got);
                failures++;
                return;
            end
            want = replies_due.pop_front();
            field_check("out_value",    want.value,     got.value);
            field_check("out_priority", want.prio,      got.prio);
            field_check("status",       want.status,    got.status);
            field_check("occupancy",    want.occupancy, got.occupancy);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   hold_replies;
    int   cycles;

    pqms_req_if req_ch();
    pqms_rsp_if rsp_ch();

    queue_mirror mirror = new();

    priority_queue_max_select uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_cmd(cmd_t c, value_t v, prio_t p);
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= c;
        req_ch.item_value    <= v;
        req_ch.item_priority <= p;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        mirror.apply_cmd(c, v, p);
    endtask

    task automatic idle_sender(int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_random(int enq_pct, int prio_top);
        int   roll;
        cmd_t c;
        roll = $urandom_range(99);
        if (roll < 3)
            c = CMD_NOP;
        else if (roll < enq_pct)
            c = CMD_ENQUEUE;
        else if ($urandom_range(9) < 7)
            c = CMD_DEQUEUE;
        else
            c = CMD_PEEK;
        send_cmd(c, value_t'($urandom), prio_t'($urandom_range(prio_top, 0)));
    endtask

    task automatic wait_drained();
        while (mirror.pending() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int    sent;
        int    phase_no;
        int    phase_len;
        int    burst;
        int    enq_pct;
        int    prio_top;
        prio_t p;
        value_t v;

        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.cmd           <= CMD_ENQUEUE;
        req_ch.item_value    <= '0;
        req_ch.item_priority <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: underflow on both reads, no-op leaves count alone
        send_cmd(CMD_PEEK,    value_t'($urandom), prio_t'($urandom));
        send_cmd(CMD_DEQUEUE, value_t'($urandom), prio_t'($urandom));
        send_cmd(CMD_NOP,     value_t'($urandom), prio_t'($urandom));
        // fill with ties at priority 9 and the field extremes at both ends
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
            begin
                v = '0;
                p = '0;
            end
            else if (i == DEPTH - 1)
            begin
                v = '1;
                p = '1;
            end
            else
            begin
                v = value_t'($urandom);
                p = (i % 3 == 1) ? prio_t'(9) : prio_t'(i % 8);
            end
            send_cmd(CMD_ENQUEUE, v, p);
        end
        send_cmd(CMD_ENQUEUE, value_t'($urandom), prio_t'($urandom));
        send_cmd(CMD_PEEK,    value_t'($urandom), prio_t'($urandom));
        send_cmd(CMD_NOP,     value_t'($urandom), prio_t'($urandom));
        repeat (3) send_cmd(CMD_DEQUEUE, value_t'($urandom), prio_t'($urandom));
        idle_sender(1);
        wait_drained();

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(2))
                0: enq_pct = 80;
                1: enq_pct = 55;
                default: enq_pct = 30;
            endcase
            case ($urandom_range(2))
                0: prio_top = 1;
                1: prio_top = 3;
                default: prio_top = (1 << PRIORITY_BITS) - 1;
            endcase
            if (phase_no == 2)
                hold_replies = 1'b1;
            phase_len = $urandom_range(90, 30);
            while (phase_len > 0 && sent < RANDOM_ITEMS)
            begin
                burst = $urandom_range(12, 1);
                for (int k = 0; k < burst && phase_len > 0; k++)
                begin
                    send_random(enq_pct, prio_top);
                    sent++;
                    phase_len--;
                end
                if ($urandom_range(3) != 0)
                    idle_sender($urandom_range(6, 1));
            end
            if (phase_no % 5 == 4)
            begin
                idle_sender(1);
                wait_drained();
            end
            phase_no++;
        end

        idle_sender(1);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mirror.pending() != 0)
        begin
            $display("%0t ns: %0d reply beats never arrived", $time, mirror.pending());
            mirror.failures++;
        end
        if (mirror.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // reply side: segments of steady, random and sparse ready, plus one long hold-off
    initial
    begin
        int mode;
        int seg_len;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            mode    = $urandom_range(2);
            seg_len = $urandom_range(150, 20);
            for (int i = 0; i < seg_len; i++)
            begin
                @(posedge clk);
                if (hold_replies)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_replies = 1'b0;
                end
                else
                    case (mode)
                        0: rsp_ch.ready <= 1'b1;
                        1: rsp_ch.ready <= $urandom_range(1);
                        default: rsp_ch.ready <= (i % 4 == 0);
                    endcase
            end
        end
    end

    initial
    begin
        reply_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.value     = rsp_ch.out_value;
                got.prio      = rsp_ch.out_priority;
                got.status    = rsp_ch.status;
                got.occupancy = rsp_ch.occupancy;
                mirror.check_reply(got);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t ns: timeout after %0d cycles", $time, cycles);
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pqms_pkg.sv
rtl/core/pqms_if.sv
rtl/core/pqms_cell.sv
rtl/core/priority_queue_max_select.sv
bench/tb_priority_queue_max_select.sv
